[src/intensity_band_peak_detector_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the intensity band peak detector
// Concurrent checks on the rising clock edge, disabled while reset is low.
// They reduce to nothing when the design is synthesised.
// ----------------------------------------------------------------------------
`ifndef INTENSITY_BAND_PEAK_DETECTOR_DEFINES_SVH
`define INTENSITY_BAND_PEAK_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define IBPD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define IBPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IBPD_ASSERT_SAME(lbl, ante, cons, msg)
`define IBPD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[src/ibpd_pkg.sv]
// ----------------------------------------------------------------------------
// Intensity band peak detector package
// Widths, register indices and reset values shared by the interfaces and the
// detector.
// ----------------------------------------------------------------------------
package ibpd_pkg;

  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned COUNT_W   = 12;
  localparam int unsigned MAX_BEAMS = 2048;
  localparam int unsigned BEAM_W    = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [BEAM_W-1:0]  beam_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAND_LOW  = 2'd0,
    REG_BAND_HIGH = 2'd1,
    REG_MIN_RUN   = 2'd2
  } cfg_reg_e;

  localparam level_t BAND_LOW_RST  = 16'd1000;
  localparam level_t BAND_HIGH_RST = 16'd2000;
  localparam count_t MIN_RUN_RST   = 12'd2;

  localparam count_t COUNT_SAT = '1;
  localparam beam_t  BEAM_LAST = beam_t'(MAX_BEAMS - 1);

endpackage

[src/ibpd_if.sv]
// ----------------------------------------------------------------------------
// Intensity band peak detector channels
// Sample channel into the detector and peak channel out of it, both with a
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface ibpd_sample_if
  import ibpd_pkg::*;
;
  logic   valid;
  logic   ready;
  level_t sample_intensity;
  logic   scan_last;

  modport source (output valid, output sample_intensity, output scan_last, input ready);
  modport sink   (input valid, input sample_intensity, input scan_last, output ready);
endinterface

interface ibpd_peak_if
  import ibpd_pkg::*;
;
  logic   valid;
  logic   ready;
  beam_t  peak_beam;
  level_t peak_level;
  logic   at_scan_end;

  modport source (output valid, output peak_beam, output peak_level, output at_scan_end,
                  input ready);
  modport sink   (input valid, input peak_beam, input peak_level, input at_scan_end,
                  output ready);
endinterface

[src/intensity_band_peak_detector.sv]
// A sample request is taken into an input register; once the output register is empty or being
// read, its band test, run bookkeeping and peak tracking are worked out in one pass and any
// result lands in the output register. One sample is accepted per cycle as long as the output
// register is empty or being read; the input register and the output register are what set
// that figure, and a stalled output holds one sample in the input register before the sample
// port deasserts ready.
// ----------------------------------------------------------------------------
// Intensity band peak detector
// Finds runs of in-band laser intensity samples and reports the strongest
// beam of each run that is long enough.
// ----------------------------------------------------------------------------
`include "intensity_band_peak_detector_defines.svh"

module intensity_band_peak_detector
  import ibpd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  ibpd_sample_if.sink          sample_i,
  ibpd_peak_if.source          peak_o
);

  // Configuration registers.
  level_t band_low_q, band_high_q;
  count_t min_run_q;

  // Input register.
  logic   in_valid_q;
  level_t in_level_q;
  logic   in_last_q;

  // Run state.
  logic   run_active_q, run_active_d;
  count_t run_count_q, run_count_d;
  level_t best_level_q, best_level_d;
  beam_t  best_beam_q, best_beam_d;
  beam_t  beam_cnt_q, beam_cnt_d;

  // Output register.
  logic   out_valid_q, out_valid_d;
  beam_t  out_beam_q;
  level_t out_level_q;
  logic   out_end_q;

  logic   advance;
  logic   in_accept;
  logic   in_band;
  count_t count_inc;
  logic   emit;
  logic   emit_end;

  assign advance   = in_valid_q && (!out_valid_q || peak_o.ready);
  assign in_accept = sample_i.valid && sample_i.ready;

  assign sample_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_low_q  <= BAND_LOW_RST;
      band_high_q <= BAND_HIGH_RST;
      min_run_q   <= MIN_RUN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BAND_LOW:  band_low_q  <= cfg_data_i[LEVEL_W-1:0];
        REG_BAND_HIGH: band_high_q <= cfg_data_i[LEVEL_W-1:0];
        REG_MIN_RUN:   min_run_q   <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      in_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_level_q <= sample_i.sample_intensity;
      in_last_q  <= sample_i.scan_last;
    end
  end

  always_comb begin
    in_band   = (in_level_q > band_low_q) && (in_level_q < band_high_q);
    count_inc = (run_count_q == COUNT_SAT) ? run_count_q : run_count_q + count_t'(1);

    run_active_d = run_active_q;
    run_count_d  = run_count_q;
    best_level_d = best_level_q;
    best_beam_d  = best_beam_q;
    emit         = 1'b0;
    emit_end     = 1'b0;

    if (in_band) begin
      run_active_d = 1'b1;
      run_count_d  = run_active_q ? count_inc : count_t'(1);
      // The earlier beam wins a tie, so only a strictly higher level replaces it.
      if (!run_active_q || (in_level_q > best_level_q)) begin
        best_level_d = in_level_q;
        best_beam_d  = beam_cnt_q;
      end
      if (in_last_q) begin
        emit         = (run_count_d >= min_run_q);
        emit_end     = 1'b1;
        run_active_d = 1'b0;
        run_count_d  = '0;
      end
    end else if (run_active_q) begin
      emit         = (run_count_q >= min_run_q);
      run_active_d = 1'b0;
      run_count_d  = '0;
    end

    if (in_last_q || (beam_cnt_q == BEAM_LAST)) begin
      beam_cnt_d = '0;
    end else begin
      beam_cnt_d = beam_cnt_q + beam_t'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = emit;
    end else if (peak_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_active_q <= 1'b0;
      run_count_q  <= '0;
      best_level_q <= '0;
      best_beam_q  <= '0;
      beam_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        run_active_q <= run_active_d;
        run_count_q  <= run_count_d;
        best_level_q <= best_level_d;
        best_beam_q  <= best_beam_d;
        beam_cnt_q   <= beam_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_beam_q  <= best_beam_d;
      out_level_q <= best_level_d;
      out_end_q   <= emit_end;
    end
  end

  assign peak_o.valid       = out_valid_q;
  assign peak_o.peak_beam   = out_beam_q;
  assign peak_o.peak_level  = out_level_q;
  assign peak_o.at_scan_end = out_end_q;

  `IBPD_ASSERT_SAME(a_run_count_tracks_active, 1'b1, run_active_q == (run_count_q != '0), "run count and run flag disagree")
  `IBPD_ASSERT_NEXT(a_scan_end_restarts, advance && in_last_q, (beam_cnt_q == '0) && !run_active_q, "scan end did not restart the beam counter")
  `IBPD_ASSERT_SAME(a_result_from_item, $rose(out_valid_q), $past(advance), "result appeared without a processed request")
  `IBPD_ASSERT_NEXT(a_held_request_kept, in_valid_q && !advance, in_valid_q && $stable(in_level_q) && $stable(in_last_q), "held request was lost")

endmodule
